// File: hdl/iab_pkg.sv
// ----------------------------------------------------------------------------
// iab_pkg
// Shared types and sizes for the insertable array buffer.
// ----------------------------------------------------------------------------
package iab_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [2:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_INSERT = 3'd2,
		FN_READ   = 3'd3,
		FN_WRITE  = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Broadcast to every cell: load value at tgt, shift up the cells above tgt
	// through hi.
	typedef struct packed {
		logic              set;
		logic              shift;
		logic [IDX_W-1:0]  tgt;
		logic [CNT_W-1:0]  hi;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

// File: hdl/iab_if.sv
// ----------------------------------------------------------------------------
// iab_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface iab_cmd_if import iab_pkg::*; ();
	logic              valid;
	logic              ready;
	func_t             func;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface iab_rsp_if import iab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [CNT_W-1:0]  count;
	status_t           status;

	modport source (output valid, output read_data, output count, output status, input ready);
	modport sink   (input valid, input read_data, input count, input status, output ready);
endinterface

// File: hdl/iab_cell.sv
// ----------------------------------------------------------------------------
// iab_cell
// One entry of the store: loads new data or takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module iab_cell import iab_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] left,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;
	logic              hit;
	logic              above;

	assign hit   = (idx == cmd.tgt);
	assign above = (idx > cmd.tgt) && (CNT_W'(idx) <= cmd.hi);

	always_ff @(posedge clk) begin
		if (cmd.set && hit) begin
			data_q <= cmd.value;
		end else if (cmd.shift && above) begin
			data_q <= left;
		end
	end

	assign data = data_q;

endmodule

// File: hdl/insertable_array_buffer.sv
// ----------------------------------------------------------------------------
// insertable_array_buffer: ordered store with push, pop, insert, read, write
// Result: registered in the output register in the cycle after an item is accepted.
// Throughput: one item per cycle while the result side is ready; all cells update in parallel.
// Reset: entry count and result valid clear; entry cells are not reset.
// ----------------------------------------------------------------------------
module insertable_array_buffer import iab_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	iab_cmd_if.sink    cmd,
	iab_rsp_if.source  rsp
);

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] rd_q;
	logic [CNT_W-1:0]  rsp_cnt_q;
	status_t           st_q;

	logic              acc;
	logic              full;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic [IDX_W-1:0]  pos_idx;
	logic [DATA_W-1:0] mux_rd;
	logic [DATA_W-1:0] rd_c;
	status_t           st_c;
	cell_cmd_t         ccmd;
	logic [DATA_W-1:0] cell_data [CAPACITY];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign pos_w     = CMP_W'(cmd.position);
	assign cnt_w     = CMP_W'(cnt_q);
	assign pos_idx   = cmd.position[IDX_W-1:0];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == 0) begin : g_first
				iab_cell u_cell (
					.clk  (clk),
					.idx  (IDX_W'(g)),
					.cmd  (ccmd),
					.left ({DATA_W{1'b0}}),
					.data (cell_data[g])
				);
			end else begin : g_rest
				iab_cell u_cell (
					.clk  (clk),
					.idx  (IDX_W'(g)),
					.cmd  (ccmd),
					.left (cell_data[g-1]),
					.data (cell_data[g])
				);
			end
		end
	endgenerate

	// AND-OR select of the addressed cell
	always_comb begin
		mux_rd = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			mux_rd = mux_rd | (cell_data[i] & {DATA_W{pos_idx == IDX_W'(i)}});
		end
	end

	always_comb begin
		ccmd       = '0;
		ccmd.value = cmd.value;
		ccmd.hi    = cnt_q;
		cnt_nxt    = cnt_q;
		st_c       = ST_OK;
		rd_c       = '0;
		unique case (cmd.func)
			FN_PUSH: begin
				if (full) begin
					st_c = ST_FULL;
				end else begin
					ccmd.set = 1'b1;
					ccmd.tgt = cnt_q[IDX_W-1:0];
					cnt_nxt  = cnt_q + CNT_W'(1);
				end
			end
			FN_POP: begin
				if (cnt_q == '0) begin
					st_c = ST_EMPTY;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			FN_INSERT: begin
				if (pos_w > cnt_w) begin
					st_c = ST_RANGE;
				end else if (full) begin
					st_c = ST_FULL;
				end else begin
					ccmd.set   = 1'b1;
					ccmd.shift = 1'b1;
					ccmd.tgt   = pos_idx;
					cnt_nxt    = cnt_q + CNT_W'(1);
				end
			end
			FN_READ: begin
				if (pos_w >= cnt_w) begin
					st_c = ST_RANGE;
				end else begin
					rd_c = mux_rd;
				end
			end
			FN_WRITE: begin
				if (pos_w >= cnt_w) begin
					st_c = ST_RANGE;
				end else begin
					ccmd.set = 1'b1;
					ccmd.tgt = pos_idx;
				end
			end
			FN_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
			end
		endcase
		// drop cell updates unless the item is taken
		ccmd.set   = ccmd.set && acc;
		ccmd.shift = ccmd.shift && acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q       <= cnt_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q      <= rd_c;
			rsp_cnt_q <= cnt_nxt;
			st_q      <= st_c;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.count     = rsp_cnt_q;
	assign rsp.status    = st_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.func == FN_PUSH && !full |=> cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
		else $error("push did not grow the count");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.count == cnt_q)
		else $error("result count differs from held count");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.read_data == '0)
		else $error("read data not zero on failed item");

endmodule

// File: tb/sv/iab_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iab_tb_pkg
// Shadow copy of the array buffer that predicts each result and checks the
// results in order of arrival.
// ----------------------------------------------------------------------------
package iab_tb_pkg;
	import iab_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  count;
		status_t           status;
	} outcome_t;

	class store_scoreboard;
		logic [DATA_W-1:0] cells [CAPACITY];
		int                held;
		outcome_t          awaited [$];
		int                ops_seen;
		int                checked;
		int                errors;
		int                status_seen [4];

		function new();
			held     = 0;
			ops_seen = 0;
			checked  = 0;
			errors   = 0;
			foreach (cells[i]) cells[i] = '0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// Apply one accepted operation to the shadow store and queue its result.
		function void note_op(func_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] data);
			outcome_t o;
			int       p;
			p           = pos;
			o.read_data = '0;
			o.status    = ST_OK;
			case (op)
			FN_PUSH: begin
				if (held >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					cells[held] = data;
					held++;
				end
			end
			FN_POP: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					held--;
					cells[held] = '0;
				end
			end
			FN_INSERT: begin
				// position check wins over the full check
				if (p > held) begin
					o.status = ST_RANGE;
				end else if (held >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					for (int i = held; i > p; i--) cells[i] = cells[i-1];
					cells[p] = data;
					held++;
				end
			end
			FN_READ: begin
				if (p >= held) o.status = ST_RANGE;
				else o.read_data = cells[p];
			end
			FN_WRITE: begin
				if (p >= held) o.status = ST_RANGE;
				else cells[p] = data;
			end
			FN_CLEAR: begin
				held = 0;
			end
			default: ;
			endcase
			o.count = CNT_W'(held);
			status_seen[o.status]++;
			ops_seen++;
			awaited = {awaited, o};
		endfunction

		function void check_result(logic [DATA_W-1:0] rd, logic [CNT_W-1:0] cnt, status_t st);
			outcome_t o;
			if (awaited.size() == 0) begin
				$error("result with no operation outstanding: read_data %h count %0d status %0d",
					rd, cnt, st);
				errors++;
				return;
			end
			o = awaited.pop_front();
			checked++;
			if (rd !== o.read_data) begin
				$error("read_data: expected %h, got %h", o.read_data, rd);
				errors++;
			end
			if (cnt !== o.count) begin
				$error("count: expected %0d, got %0d", o.count, cnt);
				errors++;
			end
			if (st !== o.status) begin
				$error("status: expected %0d, got %0d", o.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop, insert, read, write and clear operations into the array
// buffer under several idle and stall patterns and checks every result
// against a shadow store.
// ----------------------------------------------------------------------------
module tb_top;
	import iab_pkg::*;
	import iab_tb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_OPS  = 1680;

	logic            clk;
	logic            arst_n;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	int              quiet_cycles   = 0;
	store_scoreboard sb             = new();

	iab_cmd_if cmd_ch ();
	iab_rsp_if rsp_ch ();

	insertable_array_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: stall at random
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.read_data, rsp_ch.count, rsp_ch.status);
	end

	// watchdog: end the run if no item moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$error("no item moved in %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_op(func_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid    <= 1'b1;
		cmd_ch.func     <= op;
		cmd_ch.position <= pos;
		cmd_ch.value    <= data;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_op(op, pos, data);
	endtask

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(9))
		0:       return '0;
		1:       return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic run_directed();
		send_op(FN_POP, 0, '0);                 // pop on empty store
		send_op(FN_READ, 0, '0);                // read on empty store
		send_op(FN_WRITE, 0, 32'hDEAD_BEEF);
		send_op(FN_INSERT, 1, 32'h1234_5678);   // insert above count
		send_op(FN_INSERT, 0, '1);
		send_op(FN_PUSH, 0, '0);
		send_op(FN_INSERT, 1, 32'hA5A5_A5A5);   // insert in the middle
		send_op(FN_INSERT, 3, 32'h0000_0001);   // insert at count
		for (int i = 0; i < 4; i++) send_op(FN_READ, POS_W'(i), '0);
		send_op(FN_WRITE, 4, 32'h0BAD_F00D);    // write at count
		send_op(FN_WRITE, 2, 32'h5A5A_5A5A);
		send_op(FN_READ, 2, '0);
		send_op(func_t'(3'd6), 5, '1);           // unused codes do nothing
		send_op(func_t'(3'd7), 63, '1);
		send_op(FN_POP, 0, '0);
		send_op(FN_READ, 3, '0);                // read the popped slot
		send_op(FN_CLEAR, 0, '0);
		send_op(FN_READ, 0, '0);
		send_op(FN_INSERT, 32, 32'h8000_0001);
		send_op(FN_PUSH, 32, 32'h8000_0001);
		send_op(FN_READ, 0, '0);
	endtask

	// Swing between filling and draining so the store reaches full and empty.
	task automatic run_random(int n_ops);
		int               r;
		int               held;
		bit               growing;
		func_t            op;
		logic [POS_W-1:0] pos;
		growing = 1'b1;
		repeat (n_ops) begin
			held = sb.held;
			if (held == CAPACITY && $urandom_range(4) == 0) growing = 1'b0;
			else if (held == 0 && $urandom_range(2) == 0) growing = 1'b1;
			r = $urandom_range(99);
			if (r < (growing ? 30 : 10)) op = FN_PUSH;
			else if (r < (growing ? 52 : 18)) op = FN_INSERT;
			else if (r < (growing ? 62 : 53)) op = FN_POP;
			else if (r < 79) op = FN_READ;
			else if (r < (growing ? 99 : 97)) op = FN_WRITE;
			else if (r < 99) op = FN_CLEAR;
			else op = func_t'(3'($urandom_range(7, 6)));
			if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(32));
			else if (op == FN_INSERT) pos = POS_W'($urandom_range(held));
			else pos = (held > 0) ? POS_W'($urandom_range(held - 1)) : '0;
			send_op(op, pos, pick_data());
		end
	endtask

	initial begin
		int idle_mix  [4];
		int stall_mix [4];
		idle_mix  = '{0, 65, 0, 23};
		stall_mix = '{0, 0, 65, 23};
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.func     = FN_PUSH;
		cmd_ch.position = '0;
		cmd_ch.value    = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_mix[ph];
			recv_stall_pct = stall_mix[ph];
			run_random(RANDOM_OPS / 4);
		end

		// drain
		recv_stall_pct = 0;
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d operations sent and %0d results checked under four idle/stall mixes",
			sb.ops_seen, sb.checked);
		$display("status seen: ok %0d, full %0d, bad position %0d, empty pop %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE],
			sb.status_seen[ST_EMPTY]);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
